FILE: src/periodic_easing_waveform_unit_macros.svh
// ----------------------------------------------------------------------------
// periodic easing waveform unit assertion macros
// concurrent assertion wrappers shared by the unit's rtl
// ----------------------------------------------------------------------------
`ifndef PERIODIC_EASING_WAVEFORM_UNIT_MACROS_SVH
`define PERIODIC_EASING_WAVEFORM_UNIT_MACROS_SVH

// same-cycle implication
`define PEWU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PEWU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pewu_pkg.sv
// ----------------------------------------------------------------------------
// pewu_pkg
// shared widths, constants and types of the periodic easing waveform unit
// ----------------------------------------------------------------------------
package pewu_pkg;

    localparam int TIME_BITS_DEF       = 32;
    localparam int TRIG_TABLE_BITS_DEF = 10;

    localparam int IN_W    = 32;
    localparam int CFG_W   = 20;
    localparam int TOT_W   = 22;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = FRAC_W + 1;
    localparam int ALPHA_W = 16;
    localparam int SHAPE_W = 2;
    localparam int IDX_W   = 3;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [12:0] SIN_C = 13'd4639;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE       = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_HOLD_PAUSE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_IMPULSE    = 2'd2;

    localparam logic [IDX_W-1:0] REG_WAVE_SHAPE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PERIOD      = 3'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_TIME   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SNAP_TIME   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RETURN_TIME = 3'd4;
    localparam logic [IDX_W-1:0] REG_AMPLITUDE   = 3'd5;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_HOLD,
        KIND_SINE,
        KIND_DOWN,
        KIND_UP,
        KIND_CUBIC
    } kind_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] offset;
        logic [ALPHA_W-1:0] alpha;
    } result_t;

endpackage

FILE: src/pewu_mod.sv
// ----------------------------------------------------------------------------
// pewu_mod
// pipelined restoring remainder of the elapsed time by the cycle length
// ----------------------------------------------------------------------------
module pewu_mod #(
    parameter int TIME_BITS = pewu_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [TIME_BITS-1:0]       in_time,
    input  logic [pewu_pkg::TOT_W-1:0] total,
    output logic                       out_valid,
    output logic [pewu_pkg::TOT_W-1:0] out_rem
);

    localparam int TOT_W = pewu_pkg::TOT_W;

    logic                 valid_reg [TIME_BITS];
    logic                 valid_next [TIME_BITS];
    logic [TOT_W-1:0]     rem_reg [TIME_BITS];
    logic [TOT_W-1:0]     rem_next [TIME_BITS];
    logic [TIME_BITS-1:0] time_reg [TIME_BITS];
    logic [TIME_BITS-1:0] time_next [TIME_BITS];
    logic [TOT_W-1:0]     rem_src [TIME_BITS];
    logic [TIME_BITS-1:0] time_src [TIME_BITS];
    logic [TOT_W:0]       cand [TIME_BITS];

    always_comb
    begin
        valid_next[0] = in_valid;
        rem_src[0]    = '0;
        time_src[0]   = in_time;
        for (int k = 1; k < TIME_BITS; k++)
        begin
            valid_next[k] = valid_reg[k-1];
            rem_src[k]    = rem_reg[k-1];
            time_src[k]   = time_reg[k-1];
        end
        for (int k = 0; k < TIME_BITS; k++)
        begin
            cand[k] = {rem_src[k], time_src[k][TIME_BITS-1]};
            if (cand[k] >= {1'b0, total})
            begin
                rem_next[k] = TOT_W'(cand[k] - {1'b0, total});
            end
            else
            begin
                rem_next[k] = cand[k][TOT_W-1:0];
            end
            time_next[k] = time_src[k] << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TIME_BITS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            time_reg <= time_next;
        end
    end

    assign out_valid = valid_reg[TIME_BITS-1];
    assign out_rem   = rem_reg[TIME_BITS-1];

endmodule

FILE: src/pewu_div.sv
// ----------------------------------------------------------------------------
// pewu_div
// pipelined fractional divider, q = floor(num * 2^16 / den) for num <= den
// ----------------------------------------------------------------------------
module pewu_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  pewu_pkg::kind_t            in_kind,
    input  logic [pewu_pkg::CFG_W-1:0] in_num,
    input  logic [pewu_pkg::CFG_W-1:0] in_den,
    output logic                       out_valid,
    output pewu_pkg::kind_t            out_kind,
    output logic [pewu_pkg::Q_W-1:0]   out_q
);

    localparam int CFG_W = pewu_pkg::CFG_W;
    localparam int Q_W   = pewu_pkg::Q_W;

    logic             valid_reg [Q_W];
    logic             valid_next [Q_W];
    pewu_pkg::kind_t  kind_reg [Q_W];
    pewu_pkg::kind_t  kind_next [Q_W];
    logic [CFG_W-1:0] den_reg [Q_W];
    logic [CFG_W-1:0] den_next [Q_W];
    logic [CFG_W-1:0] rem_reg [Q_W];
    logic [CFG_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   q_reg [Q_W];
    logic [Q_W-1:0]   q_next [Q_W];
    logic [Q_W-1:0]   q_src [Q_W];
    logic [CFG_W:0]   cand [Q_W];
    logic             qbit [Q_W];

    always_comb
    begin
        valid_next[0] = in_valid;
        kind_next[0]  = in_kind;
        den_next[0]   = in_den;
        cand[0]       = {1'b0, in_num};
        q_src[0]      = '0;
        for (int k = 1; k < Q_W; k++)
        begin
            valid_next[k] = valid_reg[k-1];
            kind_next[k]  = kind_reg[k-1];
            den_next[k]   = den_reg[k-1];
            cand[k]       = {rem_reg[k-1], 1'b0};
            q_src[k]      = q_reg[k-1];
        end
        for (int k = 0; k < Q_W; k++)
        begin
            qbit[k] = (cand[k] >= {1'b0, den_next[k]});
            if (qbit[k])
            begin
                rem_next[k] = CFG_W'(cand[k] - {1'b0, den_next[k]});
            end
            else
            begin
                rem_next[k] = cand[k][CFG_W-1:0];
            end
            q_next[k] = {q_src[k][Q_W-2:0], qbit[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= kind_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_kind  = kind_reg[Q_W-1];
    assign out_q     = q_reg[Q_W-1];

endmodule

FILE: src/pewu_shape.sv
// ----------------------------------------------------------------------------
// pewu_shape
// phase to sine polynomial, cubic attack, alpha and scaled offset pipeline
// ----------------------------------------------------------------------------
module pewu_shape #(
    parameter int TRIG_TABLE_BITS = pewu_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  pewu_pkg::kind_t                  in_kind,
    input  logic [pewu_pkg::Q_W-1:0]         in_q,
    input  logic signed [pewu_pkg::ALPHA_W-1:0] amplitude,
    output logic                             out_valid,
    output pewu_pkg::result_t                out_result
);

    localparam int TTB  = TRIG_TABLE_BITS;
    localparam int PH_W = TTB + 2;
    localparam logic [PH_W-1:0] QUARTER = {2'b01, {TTB{1'b0}}};
    localparam logic [TTB:0]    QUARTER_I = {1'b1, {TTB{1'b0}}};
    localparam logic [12:0]     SIN_C_EXT = pewu_pkg::SIN_C;

    // stage 0: phase and fold
    logic [PH_W-1:0] ph_sin;
    logic [PH_W-1:0] ph_up;
    logic [PH_W-1:0] phase;
    logic [TTB:0]    i_fold;
    logic [16:0]     x_trig;
    logic            s0_valid_reg;
    pewu_pkg::kind_t s0_kind_reg;
    logic [16:0]     s0_x_reg;
    logic [16:0]     s0_x_next;
    logic            s0_neg_reg;

    assign ph_sin = in_q[15 -: PH_W];
    assign ph_up  = {1'b0, in_q[15 -: PH_W-1]};

    always_comb
    begin
        unique case (in_kind)
            pewu_pkg::KIND_SINE: phase = ph_sin;
            pewu_pkg::KIND_DOWN: phase = ph_sin + QUARTER;
            default:             phase = ph_up + QUARTER;
        endcase
        if (phase[TTB])
        begin
            i_fold = QUARTER_I - {1'b0, phase[TTB-1:0]};
        end
        else
        begin
            i_fold = {1'b0, phase[TTB-1:0]};
        end
        x_trig    = {i_fold, {(16 - TTB){1'b0}}};
        s0_x_next = (in_kind == pewu_pkg::KIND_CUBIC) ? in_q : x_trig;
    end

    // stage 1: square
    logic            s1_valid_reg;
    pewu_pkg::kind_t s1_kind_reg;
    logic [16:0]     s1_x_reg;
    logic            s1_neg_reg;
    logic [33:0]     s1_sq_reg;
    logic [33:0]     s1_sq_next;

    assign s1_sq_next = s0_x_reg * s0_x_reg;

    // stage 2: c * x2 and cube
    logic            s2_valid_reg;
    pewu_pkg::kind_t s2_kind_reg;
    logic [16:0]     s2_x_reg;
    logic            s2_neg_reg;
    logic [16:0]     s2_x2_reg;
    logic [13:0]     s2_t1_reg;
    logic [16:0]     s2_cu_reg;
    logic [29:0]     t1_prod;
    logic [50:0]     cu_prod;

    assign t1_prod = SIN_C_EXT * s1_sq_reg[32:16];
    assign cu_prod = s1_sq_reg * s1_x_reg;

    // stage 3: (b - t1) * x2
    logic            s3_valid_reg;
    pewu_pkg::kind_t s3_kind_reg;
    logic [16:0]     s3_x_reg;
    logic            s3_neg_reg;
    logic [16:0]     s3_cu_reg;
    logic [16:0]     s3_t2_reg;
    logic [32:0]     t2_prod;

    assign t2_prod = (pewu_pkg::SIN_B - {2'b00, s2_t1_reg}) * s2_x2_reg;

    // stage 4: (a - t2) * x
    logic            s4_valid_reg;
    pewu_pkg::kind_t s4_kind_reg;
    logic            s4_neg_reg;
    logic [16:0]     s4_cu_reg;
    logic [17:0]     s4_y_reg;
    logic [33:0]     y_prod;

    assign y_prod = (pewu_pkg::SIN_A - s3_t2_reg) * s3_x_reg;

    // stage 5: alpha
    logic                   s5_valid_reg;
    logic signed [15:0]     s5_alpha_reg;
    logic [15:0]            alpha_next;
    logic [16:0]            y_clamp;
    logic [15:0]            sine_mag;
    logic signed [18:0]     c_val;
    logic signed [18:0]     m_val;

    always_comb
    begin
        y_clamp  = (s4_y_reg > 18'd65536) ? 17'h10000 : s4_y_reg[16:0];
        sine_mag = y_clamp[16:1];
        c_val    = s4_neg_reg ? -$signed({2'b00, y_clamp}) : $signed({2'b00, y_clamp});
        m_val    = '0;
        unique case (s4_kind_reg)
            pewu_pkg::KIND_SINE:
            begin
                if (s4_neg_reg)
                begin
                    alpha_next = 16'(~sine_mag + 16'd1);
                end
                else
                begin
                    alpha_next = (sine_mag > 16'd32767) ? 16'h7fff : sine_mag;
                end
            end
            pewu_pkg::KIND_DOWN:
            begin
                m_val      = 19'sd65536 - c_val;
                alpha_next = 16'(-(m_val >>> 2));
            end
            pewu_pkg::KIND_UP:
            begin
                m_val      = 19'sd65536 + c_val;
                alpha_next = 16'(-(m_val >>> 2));
            end
            pewu_pkg::KIND_CUBIC:
            begin
                m_val      = 19'sd65536 - $signed({2'b00, s4_cu_reg});
                alpha_next = 16'(-(m_val >>> 1));
            end
            pewu_pkg::KIND_HOLD:
            begin
                alpha_next = 16'h8000;
            end
            default:
            begin
                alpha_next = '0;
            end
        endcase
    end

    // stage 6: scale
    logic               s6_valid_reg;
    logic signed [15:0] s6_alpha_reg;
    logic signed [31:0] s6_prod_reg;
    logic signed [31:0] prod_next;

    assign prod_next = s5_alpha_reg * amplitude;

    // stage 7: floor shift and saturate
    logic               s7_valid_reg;
    pewu_pkg::result_t  s7_result_reg;
    pewu_pkg::result_t  s7_result_next;
    logic signed [31:0] sh_val;

    always_comb
    begin
        sh_val               = s6_prod_reg >>> 15;
        s7_result_next.alpha = s6_alpha_reg;
        if (sh_val > 32'sd32767)
        begin
            s7_result_next.offset = 16'h7fff;
        end
        else if (sh_val < -32'sd32768)
        begin
            s7_result_next.offset = 16'h8000;
        end
        else
        begin
            s7_result_next.offset = sh_val[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_kind_reg   <= in_kind;
            s0_x_reg      <= s0_x_next;
            s0_neg_reg    <= phase[PH_W-1];

            s1_kind_reg   <= s0_kind_reg;
            s1_x_reg      <= s0_x_reg;
            s1_neg_reg    <= s0_neg_reg;
            s1_sq_reg     <= s1_sq_next;

            s2_kind_reg   <= s1_kind_reg;
            s2_x_reg      <= s1_x_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_x2_reg     <= s1_sq_reg[32:16];
            s2_t1_reg     <= t1_prod[29:16];
            s2_cu_reg     <= cu_prod[48:32];

            s3_kind_reg   <= s2_kind_reg;
            s3_x_reg      <= s2_x_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_cu_reg     <= s2_cu_reg;
            s3_t2_reg     <= t2_prod[32:16];

            s4_kind_reg   <= s3_kind_reg;
            s4_neg_reg    <= s3_neg_reg;
            s4_cu_reg     <= s3_cu_reg;
            s4_y_reg      <= y_prod[33:16];

            s5_alpha_reg  <= $signed(alpha_next);

            s6_alpha_reg  <= s5_alpha_reg;
            s6_prod_reg   <= prod_next;

            s7_result_reg <= s7_result_next;
        end
    end

    assign out_valid  = s7_valid_reg;
    assign out_result = s7_result_reg;

endmodule

FILE: src/pewu_skid.sv
// ----------------------------------------------------------------------------
// pewu_skid
// output register with one skid entry, registered ready toward the pipeline
// ----------------------------------------------------------------------------
module pewu_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pewu_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pewu_pkg::result_t out_data,
    output logic              skid_full
);

    logic              out_valid_reg;
    logic              out_valid_next;
    pewu_pkg::result_t out_data_reg;
    pewu_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    pewu_pkg::result_t skid_data_reg;
    pewu_pkg::result_t skid_data_next;
    logic              take_in;

    assign take_in = in_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (take_in)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = take_in;
            out_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

endmodule

FILE: src/periodic_easing_waveform_unit.sv
// ----------------------------------------------------------------------------
// periodic_easing_waveform_unit
// time sample in, eased waveform value alpha (q1.15) and scaled offset out
// s_* takes elapsed time in 1/1024 s units, one sample per transaction;
// m_* returns {offset, alpha} for every sample, in order.
// cfg_* writes wave_shape, period, hold_time, snap_time, return_time and
// amplitude by index 0..5; write only with no samples in flight.
// one sample per clock while the receiver keeps up; the path from input
// transaction to m_tvalid runs through the one-bit-per-stage remainder
// pipeline, the segment select register, the 17-stage fractional divider,
// the 8-stage polynomial and scaling pipeline and the output register.
// reset clears every pipeline valid bit and loads the register defaults
// (snap_time and return_time 1, the rest 0).
// when the receiver stalls, the result held on m_* stays and the next one
// drops into a skid entry; s_tready then falls and the whole pipeline
// holds until the skid entry drains.
// ----------------------------------------------------------------------------
`include "periodic_easing_waveform_unit_macros.svh"

module periodic_easing_waveform_unit #(
    parameter int TIME_BITS       = pewu_pkg::TIME_BITS_DEF,
    parameter int TRIG_TABLE_BITS = pewu_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [31:0] elapsed_time
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [15:0] alpha, [31:16] offset
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pewu_pkg::IDX_W-1:0] cfg_index,
    input  logic [pewu_pkg::CFG_W-1:0] cfg_data
);

    localparam int CFG_W   = pewu_pkg::CFG_W;
    localparam int TOT_W   = pewu_pkg::TOT_W;
    localparam int SHAPE_W = pewu_pkg::SHAPE_W;
    localparam int ALPHA_W = pewu_pkg::ALPHA_W;
    localparam int Q_W     = pewu_pkg::Q_W;

    logic [SHAPE_W-1:0]        shape_reg;
    logic [CFG_W-1:0]          period_reg;
    logic [CFG_W-1:0]          hold_reg;
    logic [CFG_W-1:0]          snap_reg;
    logic [CFG_W-1:0]          return_reg;
    logic signed [ALPHA_W-1:0] amplitude_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg     <= pewu_pkg::SHAPE_SINE;
            period_reg    <= '0;
            hold_reg      <= '0;
            snap_reg      <= CFG_W'(1);
            return_reg    <= CFG_W'(1);
            amplitude_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pewu_pkg::REG_WAVE_SHAPE:  shape_reg     <= cfg_data[SHAPE_W-1:0];
                pewu_pkg::REG_PERIOD:      period_reg    <= cfg_data;
                pewu_pkg::REG_HOLD_TIME:   hold_reg      <= cfg_data;
                pewu_pkg::REG_SNAP_TIME:   snap_reg      <= cfg_data;
                pewu_pkg::REG_RETURN_TIME: return_reg    <= cfg_data;
                pewu_pkg::REG_AMPLITUDE:   amplitude_reg <= $signed(cfg_data[ALPHA_W-1:0]);
                default:                   ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // cycle length and effective times
    logic              en;
    logic [CFG_W-1:0]  snap_eff;
    logic [CFG_W-1:0]  ret_eff;
    logic [TOT_W-1:0]  total;
    logic [TIME_BITS-1:0] time_in;

    assign snap_eff = (snap_reg == '0) ? CFG_W'(1) : snap_reg;
    assign ret_eff  = (return_reg == '0) ? CFG_W'(1) : return_reg;
    assign time_in  = TIME_BITS'(s_tdata);

    always_comb
    begin
        unique case (shape_reg)
            pewu_pkg::SHAPE_HOLD_PAUSE: total = TOT_W'(period_reg) + TOT_W'(hold_reg);
            pewu_pkg::SHAPE_IMPULSE:
                total = TOT_W'(snap_eff) + TOT_W'(hold_reg) + TOT_W'(ret_eff);
            default: total = TOT_W'(period_reg);
        endcase
    end

    logic             mod_valid;
    logic [TOT_W-1:0] mod_rem;

    pewu_mod #(
        .TIME_BITS (TIME_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_time   (time_in),
        .total     (total),
        .out_valid (mod_valid),
        .out_rem   (mod_rem)
    );

    // segment select
    logic              cls_valid_reg;
    pewu_pkg::kind_t   cls_kind_reg;
    pewu_pkg::kind_t   cls_kind_next;
    logic [CFG_W-1:0]  cls_num_reg;
    logic [CFG_W-1:0]  cls_num_next;
    logic [CFG_W-1:0]  cls_den_reg;
    logic [CFG_W-1:0]  cls_den_next;
    logic [TOT_W:0]    t2x;
    logic [TOT_W:0]    per_hold2;
    logic [TOT_W-1:0]  snap_hold;

    always_comb
    begin
        t2x          = {mod_rem, 1'b0};
        per_hold2    = (TOT_W + 1)'(period_reg) + {2'b00, hold_reg, 1'b0};
        snap_hold    = TOT_W'(snap_eff) + TOT_W'(hold_reg);
        cls_kind_next = pewu_pkg::KIND_ZERO;
        cls_num_next  = mod_rem[CFG_W-1:0];
        cls_den_next  = period_reg;
        unique case (shape_reg)
            pewu_pkg::SHAPE_SINE:
            begin
                if (period_reg != '0)
                begin
                    cls_kind_next = pewu_pkg::KIND_SINE;
                end
            end
            pewu_pkg::SHAPE_HOLD_PAUSE:
            begin
                if (period_reg == '0)
                begin
                    cls_kind_next = pewu_pkg::KIND_ZERO;
                end
                else if (t2x < (TOT_W + 1)'(period_reg))
                begin
                    cls_kind_next = pewu_pkg::KIND_DOWN;
                end
                else if (t2x < per_hold2)
                begin
                    cls_kind_next = pewu_pkg::KIND_HOLD;
                end
                else
                begin
                    cls_kind_next = pewu_pkg::KIND_UP;
                    cls_num_next  = CFG_W'(t2x - per_hold2);
                end
            end
            pewu_pkg::SHAPE_IMPULSE:
            begin
                if (mod_rem < TOT_W'(snap_eff))
                begin
                    cls_kind_next = pewu_pkg::KIND_CUBIC;
                    cls_num_next  = CFG_W'(TOT_W'(snap_eff) - mod_rem);
                    cls_den_next  = snap_eff;
                end
                else if (mod_rem < snap_hold)
                begin
                    cls_kind_next = pewu_pkg::KIND_HOLD;
                end
                else
                begin
                    cls_kind_next = pewu_pkg::KIND_UP;
                    cls_num_next  = CFG_W'(mod_rem - snap_hold);
                    cls_den_next  = ret_eff;
                end
            end
            default:
            begin
                cls_kind_next = pewu_pkg::KIND_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cls_valid_reg <= mod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_kind_reg <= cls_kind_next;
            cls_num_reg  <= cls_num_next;
            cls_den_reg  <= cls_den_next;
        end
    end

    logic            div_valid;
    pewu_pkg::kind_t div_kind;
    logic [Q_W-1:0]  div_q;

    pewu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cls_valid_reg),
        .in_kind   (cls_kind_reg),
        .in_num    (cls_num_reg),
        .in_den    (cls_den_reg),
        .out_valid (div_valid),
        .out_kind  (div_kind),
        .out_q     (div_q)
    );

    logic              shp_valid;
    pewu_pkg::result_t shp_result;

    pewu_shape #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_shape (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (div_valid),
        .in_kind    (div_kind),
        .in_q       (div_q),
        .amplitude  (amplitude_reg),
        .out_valid  (shp_valid),
        .out_result (shp_result)
    );

    pewu_pkg::result_t out_result;
    logic              skid_full;

    pewu_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shp_valid),
        .in_ready  (en),
        .in_data   (shp_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result),
        .skid_full (skid_full)
    );

    assign s_tready = en;
    assign m_tdata  = out_result;

    `PEWU_ASSERT_IMPLIES(a_skid_needs_out, clk, rst_n, skid_full, m_tvalid, "skid entry filled with empty output")
    `PEWU_ASSERT_NEXT(a_skid_kept, clk, rst_n, skid_full && !m_tready, skid_full, "skid entry dropped during stall")
    `PEWU_ASSERT_IMPLIES(a_zero_alpha, clk, rst_n, m_tvalid && (m_tdata[15:0] == 16'h0000), m_tdata[31:16] == 16'h0000, "nonzero offset for zero alpha")

endmodule
